[sv/cbe_pkg.sv]
`timescale 1ns / 1ps

package cbe_pkg;

  // Field widths of the evaluator.
  localparam int COORD_BITS  = 24;
  localparam int T_FRAC_BITS = 16;
  localparam int T_BITS      = T_FRAC_BITS + 1;
  localparam int TAN_BITS    = COORD_BITS + 3;
  localparam int ACC_BITS    = COORD_BITS + 5;

  // Coordinate differences used by the derivatives.
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int DIFF2_BITS = COORD_BITS + 2;

  // Bernstein weights: quadratic ones up to 2^(2F), cubic ones up to 2^(3F).
  localparam int W2_BITS    = 2 * T_FRAC_BITS + 1;
  localparam int W3_BITS    = 3 * T_FRAC_BITS + 1;
  localparam int W3_LO_BITS = (W3_BITS + 1) / 2;
  localparam int W3_HI_BITS = W3_BITS - W3_LO_BITS;

  // Product and sum widths in the axis datapath.
  localparam int PLO_BITS     = COORD_BITS + W3_LO_BITS + 1;
  localparam int PLO_SUM_BITS = PLO_BITS + 2;
  localparam int PHI_BITS     = COORD_BITS + W3_HI_BITS + 1;
  localparam int PHI_SUM_BITS = PHI_BITS + 2;
  localparam int PT_BITS      = COORD_BITS + W3_BITS + 3;
  localparam int TP_BITS      = DIFF_BITS + W2_BITS + 1;
  localparam int TSUM_BITS    = TP_BITS + 2;
  localparam int T3_BITS      = TSUM_BITS + 2;
  localparam int AP_BITS      = DIFF2_BITS + T_BITS + 1;
  localparam int ASUM_BITS    = AP_BITS + 1;
  localparam int A6_BITS      = ASUM_BITS + 3;

  // Pipeline depth from acceptance to the result register.
  localparam int NUM_STAGES = 6;

  // Register file.
  localparam int APB_DATA_BITS = 32;
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_BITS  = 3;
  localparam int APB_ADDR_BITS = REG_IDX_BITS + 2;

  localparam logic [REG_IDX_BITS-1:0] REG_P0_X = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_P0_Y = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_P1_X = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_P1_Y = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_P2_X = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_P2_Y = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_P3_X = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_P3_Y = 3'd7;

  // Per-stage load enables of the pipeline.
  typedef struct packed {
    logic [NUM_STAGES-1:0] ld;
  } cbe_ctrl_t;

  // Control points of one axis with their first and second differences.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] p0;
    logic signed [COORD_BITS-1:0] p1;
    logic signed [COORD_BITS-1:0] p2;
    logic signed [COORD_BITS-1:0] p3;
    logic signed [DIFF_BITS-1:0]  d0;
    logic signed [DIFF_BITS-1:0]  d1;
    logic signed [DIFF_BITS-1:0]  d2;
    logic signed [DIFF2_BITS-1:0] e0;
    logic signed [DIFF2_BITS-1:0] e1;
  } cbe_coef_t;

  // Basis weights of one parameter sample, shared by both axes.
  typedef struct packed {
    logic [W3_BITS-1:0] sss;
    logic [W3_BITS-1:0] sst3;
    logic [W3_BITS-1:0] stt3;
    logic [W3_BITS-1:0] ttt;
    logic [W2_BITS-1:0] ss;
    logic [W2_BITS-1:0] st2;
    logic [W2_BITS-1:0] tt;
    logic [T_BITS-1:0]  s;
    logic [T_BITS-1:0]  t;
  } cbe_weights_t;

endpackage

[sv/cbe_stream_if.sv]
`timescale 1ns / 1ps

// Parameter sample channel.
interface cbe_t_if;
  import cbe_pkg::*;

  logic              valid;
  logic              ready;
  logic [T_BITS-1:0] t_value;

  modport source (output valid, output t_value, input ready);
  modport sink (input valid, input t_value, output ready);
endinterface

// Result channel.
interface cbe_res_if;
  import cbe_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [TAN_BITS-1:0]   tangent_x;
  logic signed [TAN_BITS-1:0]   tangent_y;
  logic signed [TAN_BITS-1:0]   normal_x;
  logic signed [TAN_BITS-1:0]   normal_y;
  logic signed [ACC_BITS-1:0]   accel_x;
  logic signed [ACC_BITS-1:0]   accel_y;

  modport source (
    output valid, output point_x, output point_y, output tangent_x, output tangent_y,
    output normal_x, output normal_y, output accel_x, output accel_y, input ready
  );
  modport sink (
    input valid, input point_x, input point_y, input tangent_x, input tangent_y,
    input normal_x, input normal_y, input accel_x, input accel_y, output ready
  );
endinterface

[sv/cubic_bezier_evaluator.sv]
`timescale 1ns / 1ps

// Cubic Bezier evaluator: the four control points P0..P3 are written through the APB port
// as signed Q12.12 values at byte addresses 0x00 (p0_x), 0x04 (p0_y) up to 0x1C (p3_y);
// reads return them sign-extended to 32 bits. Each transaction on the input channel
// carries t in unsigned Q1.16 (values above 1.0 saturate to 1.0) and yields exactly one
// result transaction with the curve point (Q12.12), the first derivative and the normal
// (dy, -dx) (Q15.12) and the second derivative (Q17.12), all truncated toward minus
// infinity. The datapath is a six-stage pipeline (clamp, quadratic weights, cubic weights,
// coordinate products, sums, final scaling), so one t is accepted every clock cycle unless
// every stage is full and the output is stalled, and its result moves through these stages
// in order into the output register. Each stage holds its item only while the stage after
// it is full, so bubbles are squeezed out under back-pressure and input is still accepted
// while a result waits. Control points must only change while no transaction is in flight.
module cubic_bezier_evaluator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cbe_t_if.sink                               in_i,
  cbe_res_if.source                           res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cbe_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [cbe_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [cbe_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready
);
  import cbe_pkg::*;

  logic signed [COORD_BITS-1:0] coord_q [NUM_REGS];
  logic [REG_IDX_BITS-1:0]      reg_idx;
  cbe_coef_t                    coef_x_d, coef_y_d, coef_x_q, coef_y_q;
  logic [NUM_STAGES-1:0]        v_q, ld;
  cbe_ctrl_t                    ctrl;
  cbe_weights_t                 weights;
  logic                         in_acc, out_acc;
  logic signed [TAN_BITS-1:0]   tan_neg_x, tan_neg_y;

  // Register file.
  assign reg_idx = paddr[APB_ADDR_BITS-1:2];
  assign pready  = 1'b1;
  assign prdata  = APB_DATA_BITS'(coord_q[reg_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coord_q[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      coord_q[reg_idx] <= pwdata[COORD_BITS-1:0];
    end
  end

  // Coefficient sets with their differences, refreshed every cycle.
  function automatic cbe_coef_t make_coef(
    input logic signed [COORD_BITS-1:0] c0,
    input logic signed [COORD_BITS-1:0] c1,
    input logic signed [COORD_BITS-1:0] c2,
    input logic signed [COORD_BITS-1:0] c3
  );
    cbe_coef_t r;
    r.p0 = c0;
    r.p1 = c1;
    r.p2 = c2;
    r.p3 = c3;
    r.d0 = DIFF_BITS'(c1) - DIFF_BITS'(c0);
    r.d1 = DIFF_BITS'(c2) - DIFF_BITS'(c1);
    r.d2 = DIFF_BITS'(c3) - DIFF_BITS'(c2);
    r.e0 = DIFF2_BITS'(c2) - (DIFF2_BITS'(c1) <<< 1) + DIFF2_BITS'(c0);
    r.e1 = DIFF2_BITS'(c3) - (DIFF2_BITS'(c2) <<< 1) + DIFF2_BITS'(c1);
    return r;
  endfunction

  assign coef_x_d = make_coef(coord_q[REG_P0_X], coord_q[REG_P1_X],
                              coord_q[REG_P2_X], coord_q[REG_P3_X]);
  assign coef_y_d = make_coef(coord_q[REG_P0_Y], coord_q[REG_P1_Y],
                              coord_q[REG_P2_Y], coord_q[REG_P3_Y]);

  always_ff @(posedge clk_i) begin
    coef_x_q <= coef_x_d;
    coef_y_q <= coef_y_d;
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    ld[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || res_o.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign ctrl.ld    = ld;
  assign in_i.ready = ld[0];
  assign res_o.valid = v_q[NUM_STAGES-1];
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = res_o.valid && res_o.ready;

  // Datapath.
  cbe_weights u_weights (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .t_value_i (in_i.t_value),
    .weights_o (weights)
  );

  cbe_axis u_axis_x (
    .clk_i         (clk_i),
    .ctrl_i        (ctrl),
    .coef_i        (coef_x_q),
    .weights_i     (weights),
    .point_o       (res_o.point_x),
    .tangent_o     (res_o.tangent_x),
    .tangent_neg_o (tan_neg_x),
    .accel_o       (res_o.accel_x)
  );

  cbe_axis u_axis_y (
    .clk_i         (clk_i),
    .ctrl_i        (ctrl),
    .coef_i        (coef_y_q),
    .weights_i     (weights),
    .point_o       (res_o.point_y),
    .tangent_o     (res_o.tangent_y),
    .tangent_neg_o (tan_neg_y),
    .accel_o       (res_o.accel_y)
  );

  // The normal is the tangent turned by a quarter: (dy, -dx).
  assign res_o.normal_x = tan_neg_y ^ tan_neg_y ^ res_o.tangent_y;
  assign res_o.normal_y = tan_neg_x;

  // Input is refused only when every stage is full and the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> ((&v_q) && !res_o.ready))
    else $error("input refused while the pipeline can still move");

  // The number of items in flight follows the accepted transactions on both sides.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(v_q) ==
              $countones($past(v_q)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("item lost or repeated in the pipeline");

  // A delivered result with nothing behind it leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !v_q[NUM_STAGES-2]) |=> !res_o.valid)
    else $error("result repeated after delivery");

endmodule

[sv/cbe_weights.sv]
`timescale 1ns / 1ps

// Stages one to three: clamp t, then build the Bernstein basis weights.
module cbe_weights (
  input  logic                         clk_i,
  input  cbe_pkg::cbe_ctrl_t           ctrl_i,
  input  logic [cbe_pkg::T_BITS-1:0]   t_value_i,
  output cbe_pkg::cbe_weights_t        weights_o
);
  import cbe_pkg::*;

  localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << T_FRAC_BITS;

  logic [T_BITS-1:0]  t_clamp;
  logic [T_BITS-1:0]  t1_q, s1_q;
  logic [W2_BITS-1:0] ss_d, st_d, tt_d;
  logic [W2_BITS-1:0] ss2_q, st2_q, tt2_q;
  logic [T_BITS-1:0]  t2_q, s2_q;
  logic [W3_BITS-1:0] sss_d, sst_d, stt_d, ttt_d;
  cbe_weights_t       w3_d, w3_q;

  // Values above one saturate to one.
  assign t_clamp = (t_value_i > T_ONE) ? T_ONE : t_value_i;

  // Stage one: the parameter and its complement.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld[0]) begin
      t1_q <= t_clamp;
      s1_q <= T_ONE - t_clamp;
    end
  end

  // Stage two: the quadratic products.
  assign ss_d = W2_BITS'(s1_q) * W2_BITS'(s1_q);
  assign st_d = W2_BITS'(s1_q) * W2_BITS'(t1_q);
  assign tt_d = W2_BITS'(t1_q) * W2_BITS'(t1_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld[1]) begin
      ss2_q <= ss_d;
      st2_q <= st_d;
      tt2_q <= tt_d;
      s2_q  <= s1_q;
      t2_q  <= t1_q;
    end
  end

  // Stage three: the cubic products; the middle ones carry their factor of three.
  assign sss_d = W3_BITS'(ss2_q) * W3_BITS'(s2_q);
  assign sst_d = W3_BITS'(ss2_q) * W3_BITS'(t2_q);
  assign stt_d = W3_BITS'(st2_q) * W3_BITS'(t2_q);
  assign ttt_d = W3_BITS'(tt2_q) * W3_BITS'(t2_q);

  always_comb begin
    w3_d.sss  = sss_d;
    w3_d.sst3 = sst_d + (sst_d << 1);
    w3_d.stt3 = stt_d + (stt_d << 1);
    w3_d.ttt  = ttt_d;
    w3_d.ss   = ss2_q;
    w3_d.st2  = st2_q << 1;
    w3_d.tt   = tt2_q;
    w3_d.s    = s2_q;
    w3_d.t    = t2_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld[2]) begin
      w3_q <= w3_d;
    end
  end

  assign weights_o = w3_q;

endmodule

[sv/cbe_axis.sv]
`timescale 1ns / 1ps

// Stages four to six for one coordinate axis: weighted products, sums, final scaling.
module cbe_axis (
  input  logic                                 clk_i,
  input  cbe_pkg::cbe_ctrl_t                   ctrl_i,
  input  cbe_pkg::cbe_coef_t                   coef_i,
  input  cbe_pkg::cbe_weights_t                weights_i,
  output logic signed [cbe_pkg::COORD_BITS-1:0] point_o,
  output logic signed [cbe_pkg::TAN_BITS-1:0]   tangent_o,
  output logic signed [cbe_pkg::TAN_BITS-1:0]   tangent_neg_o,
  output logic signed [cbe_pkg::ACC_BITS-1:0]   accel_o
);
  import cbe_pkg::*;

  logic signed [COORD_BITS-1:0]   pc [4];
  logic        [W3_BITS-1:0]      pw [4];
  logic signed [DIFF_BITS-1:0]    tc [3];
  logic        [W2_BITS-1:0]      tw [3];
  logic signed [DIFF2_BITS-1:0]   ac [2];
  logic        [T_BITS-1:0]       aw [2];

  logic signed [PLO_BITS-1:0]     plo_q [4];
  logic signed [PHI_BITS-1:0]     phi_q [4];
  logic signed [TP_BITS-1:0]      tp_q [3];
  logic signed [AP_BITS-1:0]      ap_q [2];

  logic signed [PLO_SUM_BITS-1:0] plo_sum_d, plo_sum_q;
  logic signed [PHI_SUM_BITS-1:0] phi_sum_d, phi_sum_q;
  logic signed [TSUM_BITS-1:0]    tan_sum_d, tan_sum_q;
  logic signed [ASUM_BITS-1:0]    acc_sum_d, acc_sum_q;

  logic signed [PT_BITS-1:0]      pt_full;
  logic signed [T3_BITS-1:0]      tan_full;
  logic signed [A6_BITS-1:0]      acc_full;
  logic signed [COORD_BITS-1:0]   point_d, point_q;
  logic signed [TAN_BITS-1:0]     tan_d, tan_q, tan_neg_q;
  logic signed [ACC_BITS-1:0]     acc_d, acc_q;

  // Operand pairing of each term.
  assign pc[0] = coef_i.p0;
  assign pc[1] = coef_i.p1;
  assign pc[2] = coef_i.p2;
  assign pc[3] = coef_i.p3;
  assign pw[0] = weights_i.sss;
  assign pw[1] = weights_i.sst3;
  assign pw[2] = weights_i.stt3;
  assign pw[3] = weights_i.ttt;
  assign tc[0] = coef_i.d0;
  assign tc[1] = coef_i.d1;
  assign tc[2] = coef_i.d2;
  assign tw[0] = weights_i.ss;
  assign tw[1] = weights_i.st2;
  assign tw[2] = weights_i.tt;
  assign ac[0] = coef_i.e0;
  assign ac[1] = coef_i.e1;
  assign aw[0] = weights_i.s;
  assign aw[1] = weights_i.t;

  // Stage four: products. Cubic weights are split in two halves to keep each multiplier narrow.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld[3]) begin
      for (int i = 0; i < 4; i++) begin
        plo_q[i] <= PLO_BITS'(pc[i]) *
                    PLO_BITS'($signed({1'b0, pw[i][W3_LO_BITS-1:0]}));
        phi_q[i] <= PHI_BITS'(pc[i]) *
                    PHI_BITS'($signed({1'b0, pw[i][W3_BITS-1:W3_LO_BITS]}));
      end
      for (int i = 0; i < 3; i++) begin
        tp_q[i] <= TP_BITS'(tc[i]) * TP_BITS'($signed({1'b0, tw[i]}));
      end
      for (int i = 0; i < 2; i++) begin
        ap_q[i] <= AP_BITS'(ac[i]) * AP_BITS'($signed({1'b0, aw[i]}));
      end
    end
  end

  // Stage five: sums of the terms.
  always_comb begin
    plo_sum_d = '0;
    phi_sum_d = '0;
    for (int i = 0; i < 4; i++) begin
      plo_sum_d = plo_sum_d + PLO_SUM_BITS'(plo_q[i]);
      phi_sum_d = phi_sum_d + PHI_SUM_BITS'(phi_q[i]);
    end
    tan_sum_d = TSUM_BITS'(tp_q[0]) + TSUM_BITS'(tp_q[1]) + TSUM_BITS'(tp_q[2]);
    acc_sum_d = ASUM_BITS'(ap_q[0]) + ASUM_BITS'(ap_q[1]);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld[4]) begin
      plo_sum_q <= plo_sum_d;
      phi_sum_q <= phi_sum_d;
      tan_sum_q <= tan_sum_d;
      acc_sum_q <= acc_sum_d;
    end
  end

  // Stage six: join the halves, apply the factors of three and six, and drop the
  // fraction bits, which floors toward minus infinity.
  always_comb begin
    pt_full  = (PT_BITS'(phi_sum_q) <<< W3_LO_BITS) + PT_BITS'(plo_sum_q);
    tan_full = (T3_BITS'(tan_sum_q) <<< 1) + T3_BITS'(tan_sum_q);
    acc_full = (A6_BITS'(acc_sum_q) <<< 2) + (A6_BITS'(acc_sum_q) <<< 1);
    point_d  = pt_full[3*T_FRAC_BITS +: COORD_BITS];
    tan_d    = tan_full[2*T_FRAC_BITS +: TAN_BITS];
    acc_d    = acc_full[T_FRAC_BITS +: ACC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld[5]) begin
      point_q   <= point_d;
      tan_q     <= tan_d;
      tan_neg_q <= -tan_d;
      acc_q     <= acc_d;
    end
  end

  assign point_o       = point_q;
  assign tangent_o     = tan_q;
  assign tangent_neg_o = tan_neg_q;
  assign accel_o       = acc_q;

endmodule

[sim/cubic_bezier_evaluator_checker.sv]
`timescale 1ns / 1ps

// Watches the parameter, result and register ports of the evaluator. It keeps its own
// copy of the control points, predicts the result of every accepted parameter
// transaction and compares each result transaction with the oldest prediction.
module cubic_bezier_evaluator_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  cbe_t_if                                  in_i,
  cbe_res_if                                res_i,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic                              pready_i,
  input  logic [cbe_pkg::APB_ADDR_BITS-1:0] paddr_i,
  input  logic [cbe_pkg::APB_DATA_BITS-1:0] pwdata_i,
  input  logic [cbe_pkg::APB_DATA_BITS-1:0] prdata_i,
  output int                                mismatches_o,
  output int                                in_flight_o
);
  import cbe_pkg::*;

  localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << T_FRAC_BITS;

  typedef struct {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [TAN_BITS-1:0]   tangent_x;
    logic signed [TAN_BITS-1:0]   tangent_y;
    logic signed [TAN_BITS-1:0]   normal_x;
    logic signed [TAN_BITS-1:0]   normal_y;
    logic signed [ACC_BITS-1:0]   accel_x;
    logic signed [ACC_BITS-1:0]   accel_y;
  } curve_result_t;

  // Control point coordinates, indexed like the register file.
  logic signed [COORD_BITS-1:0] ctrl_coord [NUM_REGS];
  curve_result_t                curve_results_due [$];

  // Exact Bernstein sums along one axis, each floored once to Q12.12, Q15.12 or Q17.12.
  function automatic void bezier_axis(
    input  logic signed [COORD_BITS-1:0] c0,
    input  logic signed [COORD_BITS-1:0] c1,
    input  logic signed [COORD_BITS-1:0] c2,
    input  logic signed [COORD_BITS-1:0] c3,
    input  logic [T_BITS-1:0]            t,
    output logic signed [COORD_BITS-1:0] pt,
    output logic signed [TAN_BITS-1:0]   tan,
    output logic signed [ACC_BITS-1:0]   acc
  );
    logic signed [127:0] a0, a1, a2, a3, tw, sw, sum;
    a0 = c0;
    a1 = c1;
    a2 = c2;
    a3 = c3;
    tw = t;
    sw = (128'sd1 <<< T_FRAC_BITS) - tw;

    sum = a0 * sw * sw * sw + 3 * a1 * sw * sw * tw + 3 * a2 * sw * tw * tw
        + a3 * tw * tw * tw;
    sum = sum >>> (3 * T_FRAC_BITS);
    pt  = sum[COORD_BITS-1:0];

    sum = 3 * ((a1 - a0) * sw * sw + 2 * (a2 - a1) * sw * tw + (a3 - a2) * tw * tw);
    sum = sum >>> (2 * T_FRAC_BITS);
    tan = sum[TAN_BITS-1:0];

    sum = 6 * ((a2 - 2 * a1 + a0) * sw + (a3 - 2 * a2 + a1) * tw);
    sum = sum >>> T_FRAC_BITS;
    acc = sum[ACC_BITS-1:0];
  endfunction

  // Parameters above one are clamped to one; the normal is the rotated tangent.
  function automatic curve_result_t predict_curve(input logic [T_BITS-1:0] t_raw);
    curve_result_t    r;
    logic [T_BITS-1:0] t;
    t = (t_raw > T_ONE) ? T_ONE : t_raw;
    bezier_axis(ctrl_coord[REG_P0_X], ctrl_coord[REG_P1_X], ctrl_coord[REG_P2_X],
                ctrl_coord[REG_P3_X], t, r.point_x, r.tangent_x, r.accel_x);
    bezier_axis(ctrl_coord[REG_P0_Y], ctrl_coord[REG_P1_Y], ctrl_coord[REG_P2_Y],
                ctrl_coord[REG_P3_Y], t, r.point_y, r.tangent_y, r.accel_y);
    r.normal_x = r.tangent_y;
    r.normal_y = -r.tangent_x;
    return r;
  endfunction

  function automatic int field_mismatch(input string name, input longint want,
                                        input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Register traffic, result comparison and prediction, all sampled at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    curve_result_t want;
    int            bad;
    if (!rst_ni) begin
      foreach (ctrl_coord[i]) ctrl_coord[i] <= '0;
      curve_results_due.delete();
      mismatches_o <= 0;
      in_flight_o  <= 0;
    end else begin
      bad = 0;

      // A register transaction either updates the copy or must read it back.
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          ctrl_coord[paddr_i[APB_ADDR_BITS-1:2]] <= pwdata_i[COORD_BITS-1:0];
        end else begin
          bad += field_mismatch("prdata", ctrl_coord[paddr_i[APB_ADDR_BITS-1:2]],
                                $signed(prdata_i));
        end
      end

      // Each result transaction is held against the oldest prediction.
      if (res_i.valid && res_i.ready) begin
        if (curve_results_due.size() == 0) begin
          $error("result transaction with no parameter waiting for it");
          bad++;
        end else begin
          want = curve_results_due.pop_front();
          bad += field_mismatch("point_x", want.point_x, res_i.point_x);
          bad += field_mismatch("point_y", want.point_y, res_i.point_y);
          bad += field_mismatch("tangent_x", want.tangent_x, res_i.tangent_x);
          bad += field_mismatch("tangent_y", want.tangent_y, res_i.tangent_y);
          bad += field_mismatch("normal_x", want.normal_x, res_i.normal_x);
          bad += field_mismatch("normal_y", want.normal_y, res_i.normal_y);
          bad += field_mismatch("accel_x", want.accel_x, res_i.accel_x);
          bad += field_mismatch("accel_y", want.accel_y, res_i.accel_y);
        end
      end

      if (in_i.valid && in_i.ready) begin
        curve_results_due.push_back(predict_curve(in_i.t_value));
      end

      mismatches_o <= mismatches_o + bad;
      in_flight_o  <= curve_results_due.size();
    end
  end

endmodule

[sim/cubic_bezier_evaluator_tb.sv]
`timescale 1ns / 1ps

// Drives parameter samples and control point settings into the evaluator, applies random
// gaps and back-pressure, and judges the run by the checker's mismatch and in-flight counts.
module cubic_bezier_evaluator_tb;
  import cbe_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int NUM_PHASES      = 12;
  localparam int SAMPLES_PER_PHASE = 103;
  localparam int T_ONE           = 1 << T_FRAC_BITS;
  localparam int T_MAX           = (1 << T_BITS) - 1;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  int mismatches;
  int in_flight;
  int quiet_cycles;
  bit send_idle;
  bit take_idle;

  cbe_t_if   in_if ();
  cbe_res_if res_if ();

  cubic_bezier_evaluator u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cubic_bezier_evaluator_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .res_i        (res_if),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .mismatches_o (mismatches),
    .in_flight_o  (in_flight)
  );

  always #5 clk_i = ~clk_i;

  // Sends one parameter transaction after a random gap; returns at a falling edge.
  task automatic send_sample(input logic [T_BITS-1:0] tv);
    int gap;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_if.valid   <= 1'b0;
      in_if.t_value <= T_BITS'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.t_value <= tv;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  // Holds off the sender until every outstanding result has been taken.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (in_flight != 0) @(negedge clk_i);
  endtask

  task automatic reg_access(input bit wr, input logic [REG_IDX_BITS-1:0] idx,
                            input logic [APB_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Parameters weighted towards both ends of the range and the saturating values.
  function automatic logic [T_BITS-1:0] rand_t();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return T_BITS'(T_ONE);
      2:       return T_BITS'($urandom_range(T_ONE + 1, T_MAX));
      3:       return T_BITS'($urandom_range(0, 255));
      4:       return T_BITS'(T_ONE - $urandom_range(0, 255));
      default: return T_BITS'($urandom_range(0, T_ONE));
    endcase
  endfunction

  // Coordinates: extremes, small values near the origin, or anything at all. The
  // unused upper data bits are sometimes filled with noise.
  function automatic logic [APB_DATA_BITS-1:0] rand_coord();
    logic signed [COORD_BITS-1:0] c;
    case ($urandom_range(0, 7))
      0:       c = COORD_MAX;
      1:       c = COORD_MIN;
      2:       c = COORD_BITS'($urandom_range(0, 8191)) - COORD_BITS'(4096);
      default: c = COORD_BITS'($urandom);
    endcase
    if ($urandom_range(0, 3) == 0) return {(APB_DATA_BITS-COORD_BITS)'($urandom), c};
    return APB_DATA_BITS'(c);
  endfunction

  // The receiver stalls a random number of cycles before each result, in bursts.
  initial begin
    int stall;
    int taken;
    res_if.ready = 1'b0;
    take_idle    = 1'b1;
    taken        = 0;
    @(negedge clk_i);
    forever begin
      if (taken % 64 == 0) take_idle = ($urandom_range(0, 3) != 0);
      stall = take_idle ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      taken++;
      @(negedge clk_i);
    end
  end

  // Phases of control point settings, each followed by a stream of parameters.
  initial begin
    logic [T_BITS-1:0]        directed_t [$];
    logic [APB_DATA_BITS-1:0] coord;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_if.valid   = 1'b0;
    in_if.t_value = '0;
    send_idle     = 1'b1;
    directed_t    = '{17'h00000, 17'h00001, 17'h00002, 17'h00FFF, 17'h05555, 17'h0AAAA,
                      17'h07FFF, 17'h08000, 17'h0FFFF, T_BITS'(T_ONE), T_BITS'(T_ONE + 1),
                      17'h15555, T_BITS'(T_MAX)};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      // Read back what is held, then write every control point for this phase.
      for (int r = 0; r < NUM_REGS; r++) reg_access(1'b0, REG_IDX_BITS'(r), '0);
      for (int r = 0; r < NUM_REGS; r++) begin
        case (phase)
          0:       coord = APB_DATA_BITS'((r / 2) % 2 ? COORD_MAX : COORD_MIN);
          1:       coord = APB_DATA_BITS'(COORD_MAX);
          2:       coord = APB_DATA_BITS'(COORD_MIN);
          3:       coord = APB_DATA_BITS'((r / 2) % 2 ? COORD_MIN : COORD_MAX);
          4:       coord = '0;
          default: coord = rand_coord();
        endcase
        reg_access(1'b1, REG_IDX_BITS'(r), coord);
      end
      for (int r = 0; r < NUM_REGS; r++) reg_access(1'b0, REG_IDX_BITS'(r), '0);

      // Extreme parameters against alternating extreme control points come first.
      if (phase == 0) begin
        foreach (directed_t[i]) send_sample(directed_t[i]);
      end

      for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
        if (n % 40 == 0) send_idle = ($urandom_range(0, 3) != 0);
        if (n == SAMPLES_PER_PHASE / 2) drain_results();
        send_sample(rand_t());
      end
    end

    drain_results();
    repeat (NUM_STAGES + 4) @(negedge clk_i);
    if (mismatches == 0 && in_flight == 0) begin
      $display("cubic_bezier_evaluator_tb: done, clean");
    end else begin
      $display("cubic_bezier_evaluator_tb: done, errors");
    end
    $finish;
  end

  // Ends the run when no transaction of any kind has completed for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("cubic_bezier_evaluator_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[cubic_bezier_evaluator.f]
sv/cbe_pkg.sv
sv/cbe_stream_if.sv
sv/cbe_weights.sv
sv/cbe_axis.sv
sv/cubic_bezier_evaluator.sv
sim/cubic_bezier_evaluator_checker.sv
sim/cubic_bezier_evaluator_tb.sv
